### rtl/aoc_pkg.sv
// Shared widths, constants and pipeline types for the alpha-over compositor.
package aoc_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned S_W      = 16;
  localparam int unsigned NUM_W    = 24;
  localparam int unsigned PRE_STG  = 2;
  localparam int unsigned DIV_STG  = CH_W;
  localparam int unsigned SIDE_STG = DIV_STG + 1;
  localparam int unsigned N_STG    = PRE_STG + DIV_STG + 1;
  localparam int unsigned N_LANE   = 3;

  localparam logic [CH_W-1:0] UNORM_ONE = 8'hFF;
  localparam logic [S_W-1:0]  S_FULL    = 16'd65025;

  typedef struct packed {
    logic [S_W-1:0]  s;
    logic [CH_W-1:0] alpha;
    logic            zero;
  } aoc_side_t;

endpackage

### rtl/aoc_alpha.sv
// Shared alpha path: coverage S, output alpha and the divisor pipeline for the lanes.
module aoc_alpha (
  input  logic                                            clk_i,
  input  logic [aoc_pkg::N_STG-2:0]                       en_i,
  input  logic [aoc_pkg::CH_W-1:0]                        fa_i,
  input  logic [aoc_pkg::CH_W-1:0]                        ba_i,
  output logic [aoc_pkg::CH_W-1:0]                        fa_o,
  output logic [aoc_pkg::DIV_STG-1:0][aoc_pkg::S_W-1:0]   s_o,
  output aoc_pkg::aoc_side_t                              side_o
);
  import aoc_pkg::*;

  logic [S_W-1:0]  inv_prod_q;
  logic [CH_W-1:0] fa_q;
  logic [S_W-1:0]  s_d;
  logic [S_W-1:0]  rnd_sum;
  aoc_side_t       side_d;
  aoc_side_t       side_q [SIDE_STG];

  always_comb begin
    s_d          = S_FULL - inv_prod_q;
    rnd_sum      = s_d + {8'd0, s_d[S_W-1:CH_W]} + 16'd1;
    side_d.s     = s_d;
    side_d.alpha = rnd_sum[S_W-1:CH_W];
    side_d.zero  = (s_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      inv_prod_q <= S_W'(UNORM_ONE - fa_i) * S_W'(UNORM_ONE - ba_i);
      fa_q       <= fa_i;
    end
    if (en_i[1]) begin
      side_q[0] <= side_d;
    end
    for (int k = 1; k < SIDE_STG; k++) begin
      if (en_i[k+1]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < DIV_STG; j++) begin
      s_o[j] = side_q[j].s;
    end
  end

  assign fa_o   = fa_q;
  assign side_o = side_q[SIDE_STG-1];

endmodule

### rtl/aoc_lane.sv
// One colour lane: blend numerator and a pipelined restoring divide by S.
module aoc_lane (
  input  logic                                            clk_i,
  input  logic [aoc_pkg::N_STG-2:0]                       en_i,
  input  logic [aoc_pkg::CH_W-1:0]                        fc_i,
  input  logic [aoc_pkg::CH_W-1:0]                        bc_i,
  input  logic [aoc_pkg::CH_W-1:0]                        fa_i,
  input  logic [aoc_pkg::CH_W-1:0]                        ba_i,
  input  logic [aoc_pkg::CH_W-1:0]                        fa_s0_i,
  input  logic [aoc_pkg::DIV_STG-1:0][aoc_pkg::S_W-1:0]   s_i,
  output logic [aoc_pkg::CH_W-1:0]                        quo_o
);
  import aoc_pkg::*;

  logic [S_W-1:0]   fcfa_q;
  logic [S_W-1:0]   bcba_q;
  logic [NUM_W-1:0] num_d;
  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] rem_q [DIV_STG];
  logic [CH_W-1:0]  quo_q [DIV_STG];

  always_comb begin
    num_d = ({fcfa_q, 8'd0} - NUM_W'(fcfa_q))
          + (NUM_W'(bcba_q) * NUM_W'(UNORM_ONE - fa_s0_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      fcfa_q <= S_W'(fc_i) * S_W'(fa_i);
      bcba_q <= S_W'(bc_i) * S_W'(ba_i);
    end
    if (en_i[1]) begin
      num_q <= num_d;
    end
  end

  for (genvar j = 0; j < DIV_STG; j++) begin : g_div
    logic [NUM_W-1:0] rem_in;
    logic [CH_W-1:0]  quo_in;
    logic [NUM_W-1:0] dvs;
    logic [NUM_W:0]   diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = num_q;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      dvs  = NUM_W'(s_i[j]) << (DIV_STG - 1 - j);
      diff = {1'b0, rem_in} - {1'b0, dvs};
      ge   = ~diff[NUM_W];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[PRE_STG+j]) begin
        rem_q[j] <= ge ? diff[NUM_W-1:0] : rem_in;
        quo_q[j] <= {quo_in[CH_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_STG-1];

endmodule

### rtl/alpha_over_compositor.sv
// Top level of the straight-alpha "over" compositor: pipeline control and output merge.
//
// Lays a straight-alpha RGBA foreground pixel over a background pixel and returns the
// composite, every channel floored to 8-bit unorm; when both alphas are zero all outputs
// are zero. One pixel pair is accepted every clock cycle while in_ready_o is high. The
// pipeline holds two multiply stages, an 8-stage restoring divider (one quotient bit per
// stage) in each of the three colour lanes, and the output register.
// Stalls back up stage by stage, so empty stages are filled while the output waits.
module alpha_over_compositor (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [aoc_pkg::CH_W-1:0] fg_red_i,
  input  logic [aoc_pkg::CH_W-1:0] fg_green_i,
  input  logic [aoc_pkg::CH_W-1:0] fg_blue_i,
  input  logic [aoc_pkg::CH_W-1:0] fg_alpha_i,
  input  logic [aoc_pkg::CH_W-1:0] bg_red_i,
  input  logic [aoc_pkg::CH_W-1:0] bg_green_i,
  input  logic [aoc_pkg::CH_W-1:0] bg_blue_i,
  input  logic [aoc_pkg::CH_W-1:0] bg_alpha_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [aoc_pkg::CH_W-1:0] out_red_o,
  output logic [aoc_pkg::CH_W-1:0] out_green_o,
  output logic [aoc_pkg::CH_W-1:0] out_blue_o,
  output logic [aoc_pkg::CH_W-1:0] out_alpha_o
);
  import aoc_pkg::*;

  logic [N_STG-1:0]                 valid_q;
  logic [N_STG-1:0]                 valid_d;
  logic [N_STG:0]                   rdy;
  logic [N_STG-1:0]                 src_valid;
  logic [CH_W-1:0]                  fa_s0;
  logic [DIV_STG-1:0][S_W-1:0]      s_pipe;
  aoc_side_t                        side;
  logic [CH_W-1:0]                  fg_c   [N_LANE];
  logic [CH_W-1:0]                  bg_c   [N_LANE];
  logic [CH_W-1:0]                  quo    [N_LANE];
  logic [CH_W-1:0]                  red_q;
  logic [CH_W-1:0]                  green_q;
  logic [CH_W-1:0]                  blue_q;
  logic [CH_W-1:0]                  alpha_q;

  // stall propagates back combinationally through every full stage; an empty stage stays ready
  always_comb begin
    rdy[N_STG] = out_ready_i;
    for (int k = N_STG - 1; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
    src_valid = {valid_q[N_STG-2:0], in_valid_i};
    valid_d   = (rdy[N_STG-1:0] & src_valid) | (~rdy[N_STG-1:0] & valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign fg_c[0] = fg_red_i;
  assign fg_c[1] = fg_green_i;
  assign fg_c[2] = fg_blue_i;
  assign bg_c[0] = bg_red_i;
  assign bg_c[1] = bg_green_i;
  assign bg_c[2] = bg_blue_i;

  aoc_alpha u_alpha (
    .clk_i  (clk_i),
    .en_i   (rdy[N_STG-2:0]),
    .fa_i   (fg_alpha_i),
    .ba_i   (bg_alpha_i),
    .fa_o   (fa_s0),
    .s_o    (s_pipe),
    .side_o (side)
  );

  for (genvar l = 0; l < N_LANE; l++) begin : g_lane
    aoc_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (rdy[N_STG-2:0]),
      .fc_i    (fg_c[l]),
      .bc_i    (bg_c[l]),
      .fa_i    (fg_alpha_i),
      .ba_i    (bg_alpha_i),
      .fa_s0_i (fa_s0),
      .s_i     (s_pipe),
      .quo_o   (quo[l])
    );
  end

  // merge lanes; zero coverage forces a zero pixel
  always_ff @(posedge clk_i) begin
    if (rdy[N_STG-1]) begin
      red_q   <= side.zero ? '0 : quo[0];
      green_q <= side.zero ? '0 : quo[1];
      blue_q  <= side.zero ? '0 : quo[2];
      alpha_q <= side.zero ? '0 : side.alpha;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[N_STG-1];
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_alpha_o = alpha_q;

endmodule
